// ===== rtl/kcv_pkg.sv =====
package kcv_pkg;

  localparam int W      = 48;
  localparam int OPW    = 52;
  localparam int HALFW  = OPW / 2;
  localparam int ACCW   = 2 * OPW;
  localparam int QW     = 53;
  localparam int DW     = ACCW - QW;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_PROCESS_NOISE     = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_MEASUREMENT_NOISE = CFG_IW'(1);

  localparam logic [W-1:0] PN_RESET = W'(42949673);
  localparam logic [W-1:0] MN_RESET = W'(429496730);
  localparam logic [W-1:0] ONE_Q32  = W'(64'h1_0000_0000);
  localparam logic [W-1:0] U48_MAX  = {W{1'b1}};
  localparam logic [QW-1:0] MAG_SAT = QW'(1) << 52;

  localparam logic signed [53:0] SMAX54 = 54'sd140737488355327;
  localparam logic signed [53:0] SMIN54 = -54'sd140737488355328;

  typedef struct packed {
    logic            start;
    logic [OPW-1:0]  x;
    logic [OPW-1:0]  y;
    logic [DW-1:0]   d;
  } md_req_t;

  typedef struct packed {
    logic           done;
    logic [QW-1:0]  quo;
  } md_rsp_t;

  function automatic logic [W-1:0] sat48(input logic signed [53:0] v);
    logic [W-1:0] res;
    if (v > SMAX54) res = SMAX54[W-1:0];
    else if (v < SMIN54) res = SMIN54[W-1:0];
    else res = v[W-1:0];
    return res;
  endfunction

endpackage

// ===== rtl/kcv_if.sv =====
interface kcv_in_if;
  import kcv_pkg::*;
  logic         valid;
  logic         ready;
  logic         start_of_track;
  logic [W-1:0] meas_x;
  logic [W-1:0] meas_y;
  modport source (output valid, start_of_track, meas_x, meas_y, input ready);
  modport sink (input valid, start_of_track, meas_x, meas_y, output ready);
endinterface

interface kcv_out_if;
  import kcv_pkg::*;
  logic         valid;
  logic         ready;
  logic [W-1:0] smooth_x;
  logic [W-1:0] smooth_y;
  modport source (output valid, smooth_x, smooth_y, input ready);
  modport sink (input valid, smooth_x, smooth_y, output ready);
endinterface

interface kcv_cfg_if;
  import kcv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/kcv_muldiv.sv =====
module kcv_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  kcv_pkg::md_req_t req,
  output kcv_pkg::md_rsp_t rsp
);
  import kcv_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]       st_r;
  logic [1:0]       k_r;
  logic [5:0]       cnt_r;
  logic [OPW-1:0]   x_r, y_r;
  logic [DW-1:0]    d_r, rem_r;
  logic [ACCW-1:0]  acc_r;
  logic [QW-1:0]    quo_r;
  logic             done_r;

  logic [HALFW-1:0] xp, yp;
  logic [OPW-1:0]   prod;
  logic [1:0]       sh;
  logic [ACCW-1:0]  prod_ext;
  logic [DW:0]      rem2;
  logic             ge;

  assign xp       = k_r[1] ? x_r[OPW-1:HALFW] : x_r[HALFW-1:0];
  assign yp       = k_r[0] ? y_r[OPW-1:HALFW] : y_r[HALFW-1:0];
  assign prod     = xp * yp;
  assign sh       = 2'(k_r[1]) + 2'(k_r[0]);
  assign prod_ext = ACCW'(prod) << (HALFW * sh);
  assign rem2     = {rem_r, acc_r[QW-1]};
  assign ge       = rem2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (req.start) begin
            x_r   <= req.x;
            y_r   <= req.y;
            d_r   <= req.d;
            acc_r <= ACCW'(req.d >> 1);
            k_r   <= 2'd0;
            st_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_r <= acc_r + prod_ext;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd3) st_r <= ST_CHK;
        end
        ST_CHK: begin
          if (d_r == '0) begin
            quo_r  <= '0;
            done_r <= 1'b1;
            st_r   <= ST_IDLE;
          end else if (acc_r[ACCW-1:QW] >= d_r) begin
            quo_r  <= '1;
            done_r <= 1'b1;
            st_r   <= ST_IDLE;
          end else begin
            rem_r <= acc_r[ACCW-1:QW];
            quo_r <= '0;
            cnt_r <= 6'(QW);
            st_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? DW'(rem2 - {1'b0, d_r}) : rem2[DW-1:0];
          quo_r <= {quo_r[QW-2:0], ge};
          acc_r <= acc_r << 1;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            done_r <= 1'b1;
            st_r   <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/constant_velocity_kalman_smoother.sv =====
// constant-velocity kalman smoother for 2d position tracks
// in_bus: one beat per measurement (start_of_track, meas_x, meas_y), signed q16.32
// out_bus: one beat per measurement with the filtered position (smooth_x, smooth_y)
// cfg_bus: register writes, index 0 process noise, index 1 measurement noise;
//   always ready, write only while the block is idle
// a start beat loads the measurement as the state and the identity covariance;
//   its result goes through the ST_OUTP state into the output register
// any other beat runs the predict/update on the x axis, then the y axis, each
//   as five multiply-divide jobs on one shared unit: a split multiply of half-width
//   parts and a 53-step restoring division, cut short on a zero divisor
// such a beat keeps in_bus.ready low from the input beat until its result has
//   gone into the output register
// the output register holds its beat while out_bus.ready is low; the next input
//   beat is still taken, and its result waits until the register is free
// reset (rst_n low, synchronous) clears the state to zero, the covariance to
//   identity and the noise registers to about 0.01 and 0.1
module constant_velocity_kalman_smoother (
  input  logic             clk,
  input  logic             rst_n,
  kcv_in_if.sink           in_bus,
  kcv_out_if.source        out_bus,
  kcv_cfg_if.sink          cfg_bus
);
  import kcv_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_OUTP   = 3'd4;

  localparam logic [2:0] JOB_POS = 3'd0;
  localparam logic [2:0] JOB_VEL = 3'd1;
  localparam logic [2:0] JOB_P00 = 3'd2;
  localparam logic [2:0] JOB_P01 = 3'd3;
  localparam logic [2:0] JOB_P11 = 3'd4;

  logic [2:0]   st_r, job_r;
  logic         ax_r;
  logic [W-1:0] pn_r, mn_r;
  logic [W-1:0] pos_r [2];
  logic [W-1:0] vel_r [2];
  logic [W-1:0] c00_r [2];
  logic [W-1:0] c01_r [2];
  logic [W-1:0] c11_r [2];
  logic [W-1:0] zx_r, zy_r;
  logic [50:0]  a_r, s_r;
  logic [48:0]  b_r, c_r;
  logic [W-1:0] pp_r, mag_r;
  logic         neg_r;
  logic         outv_r;
  logic [W-1:0] ox_r, oy_r;

  md_req_t md_req;
  md_rsp_t md_rsp;

  kcv_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp));

  // prediction and innovation for the selected axis
  logic [W-1:0]         p00, p01, p11, z;
  logic [50:0]          a_c, s_c;
  logic [48:0]          b_c, c_c;
  logic signed [48:0]   sum49;
  logic [W-1:0]         pp_c;
  logic signed [49:0]   e_c, emag;

  assign p00   = c00_r[ax_r];
  assign p01   = c01_r[ax_r];
  assign p11   = c11_r[ax_r];
  assign z     = ax_r ? zy_r : zx_r;
  assign a_c   = 51'(p00) + {2'b0, p01, 1'b0} + 51'(p11) + 51'(pn_r);
  assign b_c   = 49'(p01) + 49'(p11);
  assign c_c   = 49'(p11) + 49'(pn_r);
  assign s_c   = a_c + 51'(mn_r);
  assign sum49 = $signed({pos_r[ax_r][W-1], pos_r[ax_r]})
               + $signed({vel_r[ax_r][W-1], vel_r[ax_r]});
  assign pp_c  = sat48(54'(sum49));
  assign e_c   = 50'($signed(z)) - 50'($signed(pp_c));
  assign emag  = e_c[49] ? -e_c : e_c;

  // job operands
  always_comb begin
    md_req.start = (st_r == ST_LAUNCH);
    md_req.d     = 51'(s_r);
    case (job_r)
      JOB_POS: begin md_req.x = OPW'(mag_r); md_req.y = OPW'(a_r); end
      JOB_VEL: begin md_req.x = OPW'(mag_r); md_req.y = OPW'(b_r); end
      JOB_P00: begin md_req.x = OPW'(a_r);   md_req.y = OPW'(mn_r); end
      JOB_P01: begin md_req.x = OPW'(b_r);   md_req.y = OPW'(mn_r); end
      default: begin md_req.x = OPW'(b_r);   md_req.y = OPW'(b_r); end
    endcase
  end

  // writeback of one job result
  logic [QW-1:0]      m52;
  logic signed [53:0] sv, pos_sum, vel_sum;
  logic [W-1:0]       cov_sat;
  logic [QW-1:0]      c_ext, c_diff;
  logic [W-1:0]       p11_new;

  assign m52     = (md_rsp.quo > MAG_SAT) ? MAG_SAT : md_rsp.quo;
  assign sv      = neg_r ? -$signed({1'b0, m52}) : $signed({1'b0, m52});
  assign pos_sum = 54'($signed(pp_r)) + sv;
  assign vel_sum = 54'($signed(vel_r[ax_r])) + sv;
  assign cov_sat = (md_rsp.quo > QW'(U48_MAX)) ? U48_MAX : md_rsp.quo[W-1:0];
  assign c_ext   = QW'(c_r);
  assign c_diff  = c_ext - md_rsp.quo;
  assign p11_new = (c_ext > md_rsp.quo) ? (c_diff[W] ? U48_MAX : c_diff[W-1:0]) : '0;

  assign in_bus.ready     = (st_r == ST_IDLE);
  assign cfg_bus.ready    = 1'b1;
  assign out_bus.valid    = outv_r;
  assign out_bus.smooth_x = ox_r;
  assign out_bus.smooth_y = oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      job_r  <= JOB_POS;
      ax_r   <= 1'b0;
      outv_r <= 1'b0;
      pn_r   <= PN_RESET;
      mn_r   <= MN_RESET;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        c00_r[i] <= ONE_Q32;
        c01_r[i] <= '0;
        c11_r[i] <= ONE_Q32;
      end
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          REG_PROCESS_NOISE:     pn_r <= cfg_bus.data;
          REG_MEASUREMENT_NOISE: mn_r <= cfg_bus.data;
          default: ;
        endcase
      end
      if (st_r == ST_OUTP && (!outv_r || out_bus.ready)) outv_r <= 1'b1;
      else if (out_bus.ready) outv_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_bus.valid) begin
            if (in_bus.start_of_track) begin
              pos_r[0] <= in_bus.meas_x;
              pos_r[1] <= in_bus.meas_y;
              for (int i = 0; i < 2; i++) begin
                vel_r[i] <= '0;
                c00_r[i] <= ONE_Q32;
                c01_r[i] <= '0;
                c11_r[i] <= ONE_Q32;
              end
              st_r <= ST_OUTP;
            end else begin
              zx_r <= in_bus.meas_x;
              zy_r <= in_bus.meas_y;
              ax_r <= 1'b0;
              st_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          a_r   <= a_c;
          b_r   <= b_c;
          c_r   <= c_c;
          s_r   <= s_c;
          pp_r  <= pp_c;
          mag_r <= emag[W-1:0];
          neg_r <= e_c[49];
          job_r <= JOB_POS;
          st_r  <= ST_LAUNCH;
        end
        ST_LAUNCH: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (md_rsp.done) begin
            case (job_r)
              JOB_POS: pos_r[ax_r] <= sat48(pos_sum);
              JOB_VEL: vel_r[ax_r] <= sat48(vel_sum);
              JOB_P00: c00_r[ax_r] <= cov_sat;
              JOB_P01: c01_r[ax_r] <= cov_sat;
              default: c11_r[ax_r] <= p11_new;
            endcase
            if (job_r == JOB_P11) begin
              if (!ax_r) begin
                ax_r <= 1'b1;
                st_r <= ST_PREP;
              end else begin
                st_r <= ST_OUTP;
              end
            end else begin
              job_r <= job_r + 3'd1;
              st_r  <= ST_LAUNCH;
            end
          end
        end
        ST_OUTP: begin
          if (!outv_r || out_bus.ready) begin
            ox_r   <= pos_r[0];
            oy_r   <= pos_r[1];
            st_r   <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kcv_checker.sv =====
module kcv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_start_of_track,
  input logic [kcv_pkg::W-1:0] in_meas_x,
  input logic [kcv_pkg::W-1:0] in_meas_y,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [kcv_pkg::W-1:0] out_smooth_x,
  input logic [kcv_pkg::W-1:0] out_smooth_y
);
  import kcv_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after an input beat");

  a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_start_of_track && !out_valid |=> ##1
      (out_valid && out_smooth_x == $past(in_meas_x, 2)
                 && out_smooth_y == $past(in_meas_y, 2)))
    else $error("start beat not passed through");

endmodule

bind constant_velocity_kalman_smoother kcv_checker u_kcv_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .in_start_of_track(in_bus.start_of_track),
  .in_meas_x(in_bus.meas_x),
  .in_meas_y(in_bus.meas_y),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_smooth_x(out_bus.smooth_x),
  .out_smooth_y(out_bus.smooth_y)
);
